FILE: sv/gapp_pkg.sv
// Shared constants and types of the gradient-adjusted pixel predictor.
`timescale 1ns / 1ps
`default_nettype none

package gapp_pkg;

  // Line memory depth and the supported row lengths.
  localparam int unsigned MaxRowLength = 4096;
  localparam int unsigned MinRowLength = 3;

  // Configuration port.
  localparam int unsigned RowLengthW = 13;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [CfgIdxW-1:0]    CfgRowLength   = 1'd0;
  localparam logic [CfgIdxW-1:0]    CfgDecodeMode  = 1'd1;
  localparam logic [RowLengthW-1:0] ResetRowLength = 13'd640;

  // Gradient thresholds: sharp edge, strong blend, slight blend.
  localparam int SharpThr  = 80;
  localparam int BlendThr  = 32;
  localparam int SlightThr = 8;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // One line memory entry: the previous row and the row before it.
  typedef struct packed {
    pix_t above;
    pix_t two;
  } line_t;

  // Causal neighborhood of one color component.
  typedef struct packed {
    logic [7:0] w;
    logic [7:0] ww;
    logic [7:0] n;
    logic [7:0] nn;
    logic [7:0] nw;
    logic [7:0] ne;
    logic [7:0] nne;
  } nbr_t;

endpackage

`default_nettype wire

FILE: sv/gapp_in_if.sv
// Pixel input channel of the gradient-adjusted pixel predictor.
`timescale 1ns / 1ps
`default_nettype none

interface gapp_in_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] sample_r;
  logic [7:0] sample_g;
  logic [7:0] sample_b;

  modport source (
    output valid, frame_start, sample_r, sample_g, sample_b,
    input  ready
  );

  modport sink (
    input  valid, frame_start, sample_r, sample_g, sample_b,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/gapp_out_if.sv
// Result output channel of the gradient-adjusted pixel predictor.
`timescale 1ns / 1ps
`default_nettype none

interface gapp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_r;
  logic [7:0] result_g;
  logic [7:0] result_b;

  modport source (
    output valid, result_r, result_g, result_b,
    input  ready
  );

  modport sink (
    input  valid, result_r, result_g, result_b,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/gradient_adjusted_pixel_predictor_core.sv
// Top level of the gradient-adjusted pixel predictor: position, line memory and beat flow.
`timescale 1ns / 1ps
`default_nettype none

// The core takes one RGB pixel beat per clock in raster order, unless out_if.ready stalls
// it, and returns one result beat for each through an input register and the result
// register; it sustains that rate, set by the single pass from the input register through
// the predictor to the result register. In encode mode (decode_mode = 0) a result is the
// per-component difference between the pixel and its gradient-adjusted prediction, modulo
// 256; in decode mode the input carries those differences and the result is the rebuilt
// pixel. Pixels in the first two rows or the first two columns of an image pass through
// unchanged. A beat with frame_start set restarts at row 0, column 0. row_length is
// saturated to 3..MAX_ROW_LENGTH; write configuration only while no beat is in flight.
// Both previous rows live in one line memory of MAX_ROW_LENGTH entries with one write
// port and two registered read ports. The read addresses follow the next-state column
// counter, so the north-east neighbor and the north-west entry are ready in the cycle a
// pixel is processed. A column is written back one pixel late; the last column of a row
// is written in the cycle after it, which is always free. The line memory has no reset
// and needs no clearing pass: every entry whose contents reach a result has been written
// first.

module gradient_adjusted_pixel_predictor_core #(
  parameter int unsigned MAX_ROW_LENGTH = gapp_pkg::MaxRowLength
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  gapp_in_if.sink                              in_if,
  gapp_out_if.source                           out_if,
  input  wire                                  cfg_we_i,
  input  wire  [gapp_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire  [gapp_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(MAX_ROW_LENGTH);
  localparam int unsigned LW  = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned RLW = gapp_pkg::RowLengthW;
  localparam int unsigned CW  = (LW > RLW) ? LW : RLW;

  localparam logic [1:0]    RowCntFull = 2'd2;
  localparam logic [AW-1:0] FirstPred  = AW'(2);
  localparam logic [AW-1:0] LastAddr   = AW'(MAX_ROW_LENGTH - 1);

  // Row length saturated to the supported range.
  function automatic logic [LW-1:0] eff_len(input logic [RLW-1:0] rl);
    logic [CW-1:0] v;
    v = CW'(rl);
    if (v < CW'(gapp_pkg::MinRowLength)) begin
      v = CW'(gapp_pkg::MinRowLength);
    end else if (v > CW'(MAX_ROW_LENGTH)) begin
      v = CW'(MAX_ROW_LENGTH);
    end
    return LW'(v);
  endfunction

  // Configuration registers.
  logic [RLW-1:0] row_length_q, row_length_d;
  logic           decode_mode_q, decode_mode_d;

  // Beat flow.
  logic           in_valid_q, in_valid_d;
  logic           in_fs_q;
  gapp_pkg::pix_t in_pix_q;
  logic           out_valid_q, out_valid_d;
  gapp_pkg::pix_t out_pix_q, out_pix_d;
  logic           in_acc, step;

  // Position in the image.
  logic [AW-1:0]  col_q, col_d;
  logic [1:0]     row_q, row_d;
  logic [AW-1:0]  col0, x, col_next, nxt_pos;
  logic [1:0]     row0, row1, row_next;
  logic [LW-1:0]  span, span_nxt, xp1;
  logic           wrap0, last, predict_en;

  // Neighborhood state.
  gapp_pkg::pix_t west_q, west_d, wwest_q, wwest_d, recon;
  gapp_pkg::line_t n_q, n_d;

  // Line memory.
  gapp_pkg::line_t line_mem [MAX_ROW_LENGTH];
  gapp_pkg::line_t rda_q, rdb_q, wdata;
  logic [AW-1:0]   rda_addr, rdb_addr, waddr;
  logic            we;
  logic            pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  gapp_pkg::line_t pend_data_q, pend_data_d;

  // Per-component neighborhoods.
  gapp_pkg::nbr_t  nbr_r, nbr_g, nbr_b;
  gapp_pkg::pix_t  ne_pix, nne_pix;

  assign in_acc       = in_if.valid && in_if.ready;
  assign step         = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready  = !in_valid_q || step;
  assign out_if.valid = out_valid_q;
  assign out_if.result_r = out_pix_q.r;
  assign out_if.result_g = out_pix_q.g;
  assign out_if.result_b = out_pix_q.b;

  always_comb begin
    row_length_d  = row_length_q;
    decode_mode_d = decode_mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gapp_pkg::CfgRowLength:  row_length_d  = cfg_wdata_i[RLW-1:0];
        gapp_pkg::CfgDecodeMode: decode_mode_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Column and row of the pixel in the input register, and the position after it.
  always_comb begin
    span  = eff_len(row_length_q);
    col0  = in_fs_q ? '0 : col_q;
    row0  = in_fs_q ? '0 : row_q;
    wrap0 = LW'(col0) >= span;
    x     = wrap0 ? '0 : col0;
    if (wrap0 && row0 != RowCntFull) begin
      row1 = row0 + 2'd1;
    end else begin
      row1 = row0;
    end
    xp1        = LW'(x) + LW'(1);
    last       = xp1 >= span;
    col_next   = last ? '0 : AW'(xp1);
    row_next   = (last && row1 != RowCntFull) ? row1 + 2'd1 : row1;
    predict_en = (row1 == RowCntFull) && (x >= FirstPred);
  end

  // The neighbors of column x; at the row end NE and NNE fall back to N and NN.
  always_comb begin
    ne_pix  = last ? n_q.above : rda_q.above;
    nne_pix = last ? n_q.two : rda_q.two;
    nbr_r = '{w: west_q.r, ww: wwest_q.r, n: n_q.above.r, nn: n_q.two.r,
              nw: rdb_q.above.r, ne: ne_pix.r, nne: nne_pix.r};
    nbr_g = '{w: west_q.g, ww: wwest_q.g, n: n_q.above.g, nn: n_q.two.g,
              nw: rdb_q.above.g, ne: ne_pix.g, nne: nne_pix.g};
    nbr_b = '{w: west_q.b, ww: wwest_q.b, n: n_q.above.b, nn: n_q.two.b,
              nw: rdb_q.above.b, ne: ne_pix.b, nne: nne_pix.b};
  end

  gapp_comp u_comp_r (
    .nbr_i     (nbr_r),
    .sample_i  (in_pix_q.r),
    .decode_i  (decode_mode_q),
    .predict_i (predict_en),
    .result_o  (out_pix_d.r),
    .recon_o   (recon.r)
  );

  gapp_comp u_comp_g (
    .nbr_i     (nbr_g),
    .sample_i  (in_pix_q.g),
    .decode_i  (decode_mode_q),
    .predict_i (predict_en),
    .result_o  (out_pix_d.g),
    .recon_o   (recon.g)
  );

  gapp_comp u_comp_b (
    .nbr_i     (nbr_b),
    .sample_i  (in_pix_q.b),
    .decode_i  (decode_mode_q),
    .predict_i (predict_en),
    .result_o  (out_pix_d.b),
    .recon_o   (recon.b)
  );

  // Next-state values.
  always_comb begin
    in_valid_d  = in_acc ? 1'b1 : (step ? 1'b0 : in_valid_q);
    out_valid_d = step ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
    col_d       = step ? col_next : col_q;
    row_d       = step ? row_next : row_q;
    west_d      = step ? recon : west_q;
    wwest_d     = step ? west_q : wwest_q;
    n_d         = step ? rda_q : n_q;

    // The last column is written in the following cycle, next to the old row above.
    pend_d      = step && last;
    pend_addr_d = x;
    pend_data_d = '{above: recon, two: n_q.above};

    // Column x-1 is written when pixel x arrives: the west pixel over the old row above.
    we    = pend_q || (step && x != '0);
    waddr = pend_q ? pend_addr_q : x - AW'(1);
    wdata = pend_q ? pend_data_q : '{above: west_q, two: rdb_q.above};
  end

  // Read addresses come from the position the next pixel will take, unless it starts
  // a new image; the first two columns of an image never use those reads.
  always_comb begin
    span_nxt = eff_len(row_length_d);
    nxt_pos  = (LW'(col_d) >= span_nxt) ? '0 : col_d;
    rda_addr = (nxt_pos == LastAddr) ? '0 : nxt_pos + AW'(1);
    rdb_addr = (nxt_pos == '0) ? '0 : nxt_pos - AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      line_mem[waddr] <= wdata;
    end
    if (we && waddr == rda_addr) begin
      rda_q <= wdata;
    end else begin
      rda_q <= line_mem[rda_addr];
    end
    if (we && waddr == rdb_addr) begin
      rdb_q <= wdata;
    end else begin
      rdb_q <= line_mem[rdb_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_fs_q  <= in_if.frame_start;
      in_pix_q <= '{r: in_if.sample_r, g: in_if.sample_g, b: in_if.sample_b};
    end
    if (step) begin
      out_pix_q <= out_pix_d;
    end
    n_q         <= n_d;
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= gapp_pkg::ResetRowLength;
      decode_mode_q <= 1'b0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      col_q         <= '0;
      row_q         <= '0;
      west_q        <= '0;
      wwest_q       <= '0;
      pend_q        <= 1'b0;
    end else begin
      row_length_q  <= row_length_d;
      decode_mode_q <= decode_mode_d;
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      col_q         <= col_d;
      row_q         <= row_d;
      west_q        <= west_d;
      wwest_q       <= wwest_d;
      pend_q        <= pend_d;
    end
  end

`ifndef ASSERT_OFF
  // A deferred write of the last column only follows a pixel in that column.
  a_pend_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(step && last))
    else $error("last-column write without a last-column pixel");

  // After a pixel the column counter lies inside the row.
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (LW'(col_q) < $past(span)))
    else $error("column counter left the row");

  // Every processed pixel lands in the result register.
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed pixel lost");

  // A waiting pixel stays in the input register until it is processed.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> (in_valid_q && $stable(in_pix_q)))
    else $error("waiting pixel dropped");

  // The deferred write never competes with a column write-back.
  a_port_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(step && x != '0))
    else $error("line memory write port conflict");
`endif

endmodule

`default_nettype wire

FILE: sv/gapp_comp.sv
// Gradient-adjusted prediction and delta coding of one color component.
`timescale 1ns / 1ps
`default_nettype none

module gapp_comp (
  input  gapp_pkg::nbr_t nbr_i,
  input  logic [7:0]     sample_i,
  input  logic           decode_i,
  input  logic           predict_i,
  output logic [7:0]     result_o,
  output logic [7:0]     recon_o
);

  typedef logic signed [11:0] val_t;

  localparam val_t Sharp  = val_t'(gapp_pkg::SharpThr);
  localparam val_t Blend  = val_t'(gapp_pkg::BlendThr);
  localparam val_t Slight = val_t'(gapp_pkg::SlightThr);
  localparam val_t PixMax = val_t'(255);

  function automatic val_t absd(input val_t a, input val_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Halving and quartering that truncate toward zero.
  function automatic val_t half_tz(input val_t v);
    return (v < 0) ? -((-v) >>> 1) : (v >>> 1);
  endfunction

  function automatic val_t quarter_tz(input val_t v);
    return (v < 0) ? -((-v) >>> 2) : (v >>> 2);
  endfunction

  val_t       w, ww, n, nn, nw, ne, nne;
  val_t       dh, dv, dhv, dvh, base, pred;
  logic [7:0] pred_sat;

  always_comb begin
    w   = val_t'({4'b0000, nbr_i.w});
    ww  = val_t'({4'b0000, nbr_i.ww});
    n   = val_t'({4'b0000, nbr_i.n});
    nn  = val_t'({4'b0000, nbr_i.nn});
    nw  = val_t'({4'b0000, nbr_i.nw});
    ne  = val_t'({4'b0000, nbr_i.ne});
    nne = val_t'({4'b0000, nbr_i.nne});

    dh  = absd(w, ww) + absd(n, nw) + absd(ne, n);
    dv  = absd(w, nw) + absd(n, nn) + absd(ne, nne);
    dhv = dh - dv;
    dvh = dv - dh;

    base = half_tz(n + w) + quarter_tz(ne - nw);

    if (dhv > Sharp) begin
      pred = n;
    end else if (dvh > Sharp) begin
      pred = w;
    end else if (dhv > Blend) begin
      pred = half_tz(base + n);
    end else if (dvh > Blend) begin
      pred = half_tz(base + w);
    end else if (dhv > Slight) begin
      pred = quarter_tz(base + (base <<< 1) + n);
    end else if (dvh > Slight) begin
      pred = quarter_tz(base + (base <<< 1) + w);
    end else begin
      pred = base;
    end

    if (pred < 0) begin
      pred_sat = 8'd0;
    end else if (pred > PixMax) begin
      pred_sat = 8'd255;
    end else begin
      pred_sat = pred[7:0];
    end

    if (!predict_i) begin
      recon_o  = sample_i;
      result_o = sample_i;
    end else if (decode_i) begin
      recon_o  = sample_i + pred_sat;
      result_o = sample_i + pred_sat;
    end else begin
      recon_o  = sample_i;
      result_o = sample_i - pred_sat;
    end
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench of the gradient-adjusted pixel predictor core.
`timescale 1ns / 1ps

module testbench;

  // One pixel as three bytes: index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][7:0] trio_t;

  // Content styles of the random images. Ramps and edges keep the gradients in the
  // range where the blending thresholds matter; dim images push the prediction to its
  // clamps and, in decode mode, make small deltas that rebuild smooth images.
  typedef enum int {StyleNoise, StyleRamp, StyleEdge, StyleDim} style_e;

  // One row of the directed table: either a register write or a pixel beat. A pixel
  // row with known set carries its result, which is then used instead of the predictor.
  typedef struct {
    logic                          is_cfg;
    logic [gapp_pkg::CfgIdxW-1:0]  reg_idx;
    logic [gapp_pkg::CfgDataW-1:0] reg_val;
    logic                          fs;
    gapp_pkg::pix_t                px;
    logic                          known;
    gapp_pkg::pix_t                want;
  } plan_row_t;

  typedef struct {
    logic           known;
    gapp_pkg::pix_t value;
  } typed_t;

  localparam int RandomItems = 1450;
  localparam int LongStall   = 64;
  localparam int DrainCycles = 4;

  logic clk;
  logic rst_ni;
  logic cfg_we;
  logic [gapp_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [gapp_pkg::CfgDataW-1:0] cfg_wdata;

  gapp_in_if  in_ch ();
  gapp_out_if out_ch ();

  gradient_adjusted_pixel_predictor_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state: the two line memories, the last two rebuilt pixels, the position
  // within the image and a copy of both registers.
  trio_t                           north_line [gapp_pkg::MaxRowLength];
  trio_t                           north2_line [gapp_pkg::MaxRowLength];
  trio_t                           west_px;
  trio_t                           west2_px;
  int unsigned                     col_pos;
  int unsigned                     row_pos;
  logic [gapp_pkg::RowLengthW-1:0] row_len_reg;
  logic                            decode_reg;

  gapp_pkg::pix_t pending_results[$];
  typed_t         typed_results[$];
  int             mismatch_count;

  // Knobs shared between the stimulus and the result sink.
  logic   in_calm;
  logic   out_calm;
  logic   stall_request;
  style_e phase_style;
  int     phase_base;
  int     phase_sx;
  int     phase_sy;
  int     phase_edge;

  string channel_name [3] = '{"blue", "green", "red"};

  // Directed part: a five-pixel image through its first two rows (all pass through),
  // then a shrink of the row length in the middle of row 2, a switch to decode mode
  // in the middle of the image, an out-of-range low length that saturates to 3, and
  // an out-of-range high length that saturates to the line memory depth.
  plan_row_t directed_plan [31] = '{
    '{1'b1, gapp_pkg::CfgRowLength,  13'd5,    1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, gapp_pkg::CfgDecodeMode, 13'd0,    1'b0, 24'h000000, 1'b0, 24'h000000},
    // Row 0 of a new image: every pixel comes back as it went in.
    '{1'b0, '0, '0, 1'b1, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, '0, '0, 1'b0, 24'hffffff, 1'b1, 24'hffffff},
    '{1'b0, '0, '0, 1'b0, 24'h807f01, 1'b1, 24'h807f01},
    '{1'b0, '0, '0, 1'b0, 24'h01fe55, 1'b1, 24'h01fe55},
    '{1'b0, '0, '0, 1'b0, 24'haa55ff, 1'b1, 24'haa55ff},
    // Row 1: still raw.
    '{1'b0, '0, '0, 1'b0, 24'h102030, 1'b1, 24'h102030},
    '{1'b0, '0, '0, 1'b0, 24'h405060, 1'b1, 24'h405060},
    '{1'b0, '0, '0, 1'b0, 24'h708090, 1'b1, 24'h708090},
    '{1'b0, '0, '0, 1'b0, 24'hff00ff, 1'b1, 24'hff00ff},
    '{1'b0, '0, '0, 1'b0, 24'h00ff00, 1'b1, 24'h00ff00},
    // Row 2: the first two columns are raw, column 2 is predicted.
    '{1'b0, '0, '0, 1'b0, 24'h202020, 1'b1, 24'h202020},
    '{1'b0, '0, '0, 1'b0, 24'h303030, 1'b1, 24'h303030},
    '{1'b0, '0, '0, 1'b0, 24'h6090c0, 1'b0, 24'h000000},
    // Shrinking to 3 with three pixels of the row done ends the row right here.
    '{1'b1, gapp_pkg::CfgRowLength,  13'd3,    1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, '0, '0, 1'b0, 24'h000000, 1'b1, 24'h000000},
    '{1'b0, '0, '0, 1'b0, 24'hffffff, 1'b1, 24'hffffff},
    '{1'b0, '0, '0, 1'b0, 24'h804020, 1'b0, 24'h000000},
    '{1'b1, gapp_pkg::CfgDecodeMode, 13'd1,    1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, '0, '0, 1'b0, 24'h050607, 1'b1, 24'h050607},
    '{1'b0, '0, '0, 1'b0, 24'hf00f99, 1'b1, 24'hf00f99},
    '{1'b0, '0, '0, 1'b0, 24'h00ff01, 1'b0, 24'h000000},
    '{1'b1, gapp_pkg::CfgRowLength,  13'd0,    1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b1, gapp_pkg::CfgDecodeMode, 13'd0,    1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, '0, '0, 1'b0, 24'h112233, 1'b1, 24'h112233},
    '{1'b0, '0, '0, 1'b0, 24'h445566, 1'b1, 24'h445566},
    '{1'b0, '0, '0, 1'b0, 24'hff8000, 1'b0, 24'h000000},
    // A longer row needs a new image, or row 2 would read columns never written.
    '{1'b1, gapp_pkg::CfgRowLength,  13'd8191, 1'b0, 24'h000000, 1'b0, 24'h000000},
    '{1'b0, '0, '0, 1'b1, 24'h123456, 1'b1, 24'h123456},
    '{1'b0, '0, '0, 1'b0, 24'hfedcba, 1'b1, 24'hfedcba}
  };

  function automatic int unsigned span_of(input logic [gapp_pkg::CfgDataW-1:0] v);
    if (v < gapp_pkg::MinRowLength) return gapp_pkg::MinRowLength;
    if (v > gapp_pkg::MaxRowLength) return gapp_pkg::MaxRowLength;
    return int'(v);
  endfunction

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Gradient-adjusted prediction of one component. Integer division truncates toward
  // zero, as the block's arithmetic does, and the result is clamped to a byte.
  function automatic int grad_predict(input int w, input int ww, input int n, input int nn,
                                      input int nw, input int ne, input int nne);
    int dh;
    int dv;
    int p;
    dh = mag(w - ww) + mag(n - nw) + mag(ne - n);
    dv = mag(w - nw) + mag(n - nn) + mag(ne - nne);
    if (dh - dv > gapp_pkg::SharpThr) begin
      p = n;
    end else if (dv - dh > gapp_pkg::SharpThr) begin
      p = w;
    end else begin
      p = (n + w) / 2 + (ne - nw) / 4;
      if (dh - dv > gapp_pkg::BlendThr) begin
        p = (p + n) / 2;
      end else if (dv - dh > gapp_pkg::BlendThr) begin
        p = (p + w) / 2;
      end else if (dh - dv > gapp_pkg::SlightThr) begin
        p = (3 * p + n) / 4;
      end else if (dv - dh > gapp_pkg::SlightThr) begin
        p = (3 * p + w) / 4;
      end
    end
    if (p < 0) p = 0;
    if (p > 255) p = 255;
    return p;
  endfunction

  // Works out the result of one accepted pixel beat and advances the predictor state.
  function automatic gapp_pkg::pix_t next_result(input logic fs, input gapp_pkg::pix_t smp);
    int unsigned len;
    int unsigned x;
    logic        last;
    trio_t       s;
    trio_t       rec;
    trio_t       res;
    int          c;
    int          n;
    int          nn;
    int          ne;
    int          nne;
    int          p;
    len = span_of(row_len_reg);
    s = smp;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // A row length shrunk below the current column ends the row first.
    if (col_pos >= len) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end
    x = col_pos;
    last = (x + 1 >= len);
    for (c = 0; c < 3; c++) begin
      if (row_pos < 2 || x < 2) begin
        rec[c] = s[c];
        res[c] = s[c];
      end else begin
        n   = north_line[x][c];
        nn  = north2_line[x][c];
        // In the last column the north-east pair falls back to the north pair.
        ne  = last ? n : int'(north_line[x+1][c]);
        nne = last ? nn : int'(north2_line[x+1][c]);
        p = grad_predict(west_px[c], west2_px[c], n, nn, north_line[x-1][c], ne, nne);
        if (decode_reg) begin
          rec[c] = s[c] + 8'(p);
          res[c] = rec[c];
        end else begin
          rec[c] = s[c];
          res[c] = s[c] - 8'(p);
        end
      end
    end
    // The line memories take a column one pixel late, the last column at once.
    if (x >= 1) begin
      north2_line[x-1] = north_line[x-1];
      north_line[x-1]  = west_px;
    end
    if (last) begin
      north2_line[x] = north_line[x];
      north_line[x]  = rec;
    end
    west2_px = west_px;
    west_px  = rec;
    col_pos  = x + 1;
    if (col_pos >= len) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end
    return res;
  endfunction

  // Content of one random pixel at image position (x, y) in the style of the phase.
  function automatic gapp_pkg::pix_t make_pixel(input int x, input int y);
    trio_t v;
    int    c;
    int    t;
    for (c = 0; c < 3; c++) begin
      case (phase_style)
        StyleNoise: begin
          t = int'($urandom_range(0, 255));
        end
        StyleRamp: begin
          t = phase_base + 37 * c + x * phase_sx + y * phase_sy
              + int'($urandom_range(0, 6)) - 3;
        end
        StyleEdge: begin
          if ((x >= phase_edge) ^ (phase_sy[0] && (y % 3 == 0))) begin
            t = 200 + 20 * c;
          end else begin
            t = 20 + 10 * c;
          end
          t = t + int'($urandom_range(0, 4));
        end
        default: begin
          t = int'($urandom_range(0, 6)) - 3;
        end
      endcase
      v[c] = 8'(t);
    end
    return v;
  endfunction

  // Lowers valid, waits until every expected result has come back, then lets the
  // pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_register(input logic [gapp_pkg::CfgIdxW-1:0] idx,
                                input logic [gapp_pkg::CfgDataW-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      gapp_pkg::CfgRowLength:  row_len_reg = val[gapp_pkg::RowLengthW-1:0];
      gapp_pkg::CfgDecodeMode: decode_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offers one pixel beat after a random gap and returns at the edge that takes it.
  // Valid stays high afterwards, so a back-to-back beat needs no second assignment.
  task automatic send_pixel(input logic fs, input gapp_pkg::pix_t px, input logic known,
                            input gapp_pkg::pix_t want);
    int gap;
    gap = in_calm ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    typed_results.push_back('{known, want});
    in_ch.valid       <= 1'b1;
    in_ch.frame_start <= fs;
    in_ch.sample_r    <= px.r;
    in_ch.sample_g    <= px.g;
    in_ch.sample_b    <= px.b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state after reset.
  initial begin
    west_px        = '0;
    west2_px       = '0;
    col_pos        = 0;
    row_pos        = 0;
    row_len_reg    = gapp_pkg::ResetRowLength;
    decode_reg     = 1'b0;
    mismatch_count = 0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    stall_request  = 1'b0;
    phase_style    = StyleNoise;
    phase_base     = 0;
    phase_sx       = 0;
    phase_sy       = 0;
    phase_edge     = 0;
  end

  // Both handshakes are sampled at the rising edge. A pixel beat is run through the
  // predictor first, then a result beat is compared with the oldest expectation.
  always @(posedge clk) begin : beat_monitor
    typed_t         tr;
    gapp_pkg::pix_t predicted;
    trio_t          want;
    trio_t          got;
    logic           bad;
    int             c;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted = next_result(in_ch.frame_start,
                                {in_ch.sample_r, in_ch.sample_g, in_ch.sample_b});
        tr = typed_results.pop_front();
        pending_results.push_back(tr.known ? tr.value : predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_r, out_ch.result_g, out_ch.result_b};
        if (pending_results.size() == 0) begin
          $display("%0t: result beat %h arrived with nothing expected", $time, got);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          bad = 1'b0;
          for (c = 2; c >= 0; c--) begin
            if (got[c] !== want[c]) begin
              $display("%0t: %s mismatch, expected %02h, got %02h",
                       $time, channel_name[c], want[c], got[c]);
              bad = 1'b1;
            end
          end
          if (bad) mismatch_count++;
        end
      end
    end
  end

  // Result sink: a random hold-off before every beat, none in calm phases, and once
  // a long hold-off while the sender keeps offering, so the core backs up to its input.
  initial begin : result_sink
    int hold;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        hold = LongStall;
      end else begin
        hold = out_calm ? 0 : int'($urandom_range(0, 6));
      end
      if (hold > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int                            i;
    int                            k;
    int                            pick;
    int                            random_sent;
    int                            n_items;
    int unsigned                   old_span;
    int unsigned                   new_span;
    int unsigned                   gx;
    int unsigned                   gy;
    logic                          start_fs;
    logic                          fs;
    logic                          stall_done;
    logic [gapp_pkg::CfgDataW-1:0] lv;

    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.frame_start <= 1'b0;
    in_ch.sample_r    <= '0;
    in_ch.sample_g    <= '0;
    in_ch.sample_b    <= '0;
    random_sent = 0;
    stall_done  = 1'b0;
    gy          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    for (i = 0; i < 31; i++) begin
      if (directed_plan[i].is_cfg) begin
        write_register(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      end else begin
        send_pixel(directed_plan[i].fs, directed_plan[i].px, directed_plan[i].known,
                   directed_plan[i].want);
      end
    end

    // Random phases: each may change the row length and the mode, then streams
    // pixels of one image style. Short rows dominate so that most beats reach row 2 and
    // the predictor; the longest rows only see a few beats.
    while (random_sent < RandomItems) begin
      wait_idle();
      old_span = span_of(row_len_reg);
      if ($urandom_range(0, 3) != 0) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 70) begin
          lv = gapp_pkg::CfgDataW'($urandom_range(3, 12));
        end else if (pick < 85) begin
          lv = gapp_pkg::CfgDataW'($urandom_range(13, 40));
        end else if (pick < 90) begin
          lv = gapp_pkg::CfgDataW'($urandom_range(0, 2));
        end else if (pick < 95) begin
          lv = gapp_pkg::CfgDataW'($urandom_range(4097, 8191));
        end else begin
          lv = gapp_pkg::CfgDataW'($urandom_range(4090, 4096));
        end
        write_register(gapp_pkg::CfgRowLength, lv);
      end
      if ($urandom_range(0, 1) != 0) begin
        write_register(gapp_pkg::CfgDecodeMode, gapp_pkg::CfgDataW'($urandom_range(0, 1)));
      end
      new_span = span_of(row_len_reg);

      // A longer row, or a shorter one before two rows of this length are complete,
      // would read line memory columns that were never written: start a new image.
      start_fs = (new_span > old_span) || (new_span < old_span && row_pos < 2)
                 || ($urandom_range(0, 3) == 0);

      if (new_span > 64) begin
        n_items = int'($urandom_range(4, 30));
      end else begin
        n_items = int'(new_span) * int'($urandom_range(2, 6))
                  + int'($urandom_range(0, new_span));
      end
      phase_style = style_e'($urandom_range(0, 3));
      phase_base  = int'($urandom_range(0, 255));
      phase_sx    = int'($urandom_range(0, 60)) - 30;
      phase_sy    = int'($urandom_range(0, 60)) - 30;
      phase_edge  = int'($urandom_range(0, new_span));
      in_calm     = ($urandom_range(0, 4) == 0);
      out_calm    = ($urandom_range(0, 4) == 0);
      if (!stall_done && random_sent >= RandomItems / 2) begin
        stall_done    = 1'b1;
        stall_request = 1'b1;
        in_calm       = 1'b1;
        out_calm      = 1'b0;
      end

      if (start_fs) begin
        gx = 0;
        gy = 0;
      end else begin
        gx = col_pos;
        if (gx >= new_span) begin
          gx = 0;
          gy++;
        end
      end

      for (k = 0; k < n_items && random_sent < RandomItems; k++) begin
        // A rare frame start in the middle of an image restarts the position.
        fs = (k == 0 && start_fs) || ($urandom_range(0, 149) == 0);
        if (fs) begin
          gx = 0;
          gy = 0;
        end
        send_pixel(fs, make_pixel(int'(gx), int'(gy)), 1'b0, '0);
        random_sent++;
        gx++;
        if (gx >= new_span) begin
          gx = 0;
          gy++;
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/gapp_pkg.sv
sv/gapp_in_if.sv
sv/gapp_out_if.sv
sv/gapp_comp.sv
sv/gradient_adjusted_pixel_predictor_core.sv
bench/testbench.sv
